// ===== rtl/core/trapezoid_profile_point_timer_core_assert.svh =====
// Assertion macros shared by the point timer RTL
`ifndef TRAPEZOID_PROFILE_POINT_TIMER_CORE_ASSERT_SVH
`define TRAPEZOID_PROFILE_POINT_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define TPPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point timer check failed");

// Next-cycle implication, masked during reset
`define TPPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point timer check failed");

`endif

// ===== rtl/core/tppt_pkg.sv =====
// Shared types, constants and register indexes of the point timer
package tppt_pkg;

    localparam int WORD_W        = 64;
    localparam int PROD_W        = 128;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int SEG_W         = 32;
    localparam int OUT_TIME_W    = 48;
    localparam int DIST_BITS_DEF = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam logic [WORD_W-1:0] NS1     = 64'd1000000000;
    localparam logic [WORD_W-1:0] NS2     = 64'd1000000000000000000;
    localparam logic [WORD_W-1:0] BUMP_NS = 64'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 2'd2;

    typedef struct packed {
        logic [SEG_W-1:0] segment_length;
        logic             first;
    } t_in_req;

    typedef struct packed {
        logic [OUT_TIME_W-1:0] time_ns;
        logic                  error;
    } t_out_req;

    // One pass of the arithmetic engine: (mul_a*mul_b + addend) [/ divisor] [sqrt]
    typedef struct packed {
        logic [WORD_W-1:0] mul_a;
        logic [WORD_W-1:0] mul_b;
        logic [WORD_W-1:0] addend;
        logic [WORD_W-1:0] divisor;
        logic              do_div;
        logic              do_sqrt;
        logic              round_up;
    } t_cmd;

endpackage

// ===== rtl/core/tppt_mul.sv =====
// Bit-serial shift-add multiplier with preloaded addend
module tppt_mul import tppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    input  logic [WORD_W-1:0] i_add,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [WORD_W-1:0] r_mplier;

    // Run one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulate shifted multiplicand
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= PROD_W'(i_add);
            r_mcand  <= PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== rtl/core/tppt_div.sv =====
// Restoring divider, one quotient bit per cycle
module tppt_div import tppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [WORD_W-1:0] i_dvs,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(PROD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvs;
    logic [WORD_W:0]   w_shift;
    logic [WORD_W:0]   w_diff;
    logic              w_ge;

    // Bring down next numerator bit and trial-subtract
    assign w_shift = {r_rem, r_num[PROD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift quotient bits into the numerator register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WORD_W-1:0] : w_shift[WORD_W-1:0];
            r_num <= {r_num[PROD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// ===== rtl/core/tppt_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle, optional round half up
module tppt_sqrt import tppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_rad,
    input  logic              i_round,
    output logic              o_done,
    output logic [WORD_W-1:0] o_root
);
    localparam int CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_fix;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_rad;
    logic [WORD_W+1:0] r_rem;
    logic [WORD_W-1:0] r_root;
    logic              r_round;
    logic [WORD_W+1:0] w_cur;
    logic [WORD_W+1:0] w_trial;
    logic              w_ge;
    logic              w_inc;

    // Bring down two radicand bits, try root*4+1
    assign w_cur   = {r_rem[WORD_W-1:0], r_rad[PROD_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = w_cur >= w_trial;
    // Round up when remainder exceeds root, unless the root is all ones
    assign w_inc   = r_round && (r_rem > {2'b00, r_root}) && (r_root != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad   <= i_rad;
            r_rem   <= '0;
            r_root  <= '0;
            r_round <= i_round;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_cur - w_trial) : w_cur;
            r_root <= {r_root[WORD_W-2:0], w_ge};
        end else if (r_fix && w_inc) begin
            r_root <= r_root + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== rtl/core/tppt_arith.sv =====
// Arithmetic engine: chains the serial multiplier, divider and square root
module tppt_arith import tppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_cmd              i_cmd,
    output logic              o_done,
    output logic [PROD_W-1:0] o_res
);
    logic              r_do_div;
    logic              r_do_sqrt;
    logic              r_round;
    logic [WORD_W-1:0] r_divisor;
    logic              r_done;
    logic [PROD_W-1:0] r_res;

    logic              w_mul_done;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start;
    logic              w_div_done;
    logic [PROD_W-1:0] w_quo;
    logic              w_sqrt_start;
    logic              w_sqrt_done;
    logic [WORD_W-1:0] w_root;
    logic              w_fin;

    // Hand each stage's result to the next one the command asks for
    assign w_div_start  = w_mul_done & r_do_div;
    assign w_sqrt_start = (w_mul_done & ~r_do_div & r_do_sqrt) | (w_div_done & r_do_sqrt);
    assign w_fin        = (w_mul_done & ~r_do_div & ~r_do_sqrt)
                        | (w_div_done & ~r_do_sqrt) | w_sqrt_done;

    tppt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_a     (i_cmd.mul_a),
        .i_b     (i_cmd.mul_b),
        .i_add   (i_cmd.addend),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    tppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_dvs   (r_divisor),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    tppt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (r_do_div ? w_quo : w_prod),
        .i_round (r_round),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Hold the command flags for the later stages
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_do_div  <= i_cmd.do_div;
            r_do_sqrt <= i_cmd.do_sqrt;
            r_round   <= i_cmd.round_up;
            r_divisor <= i_cmd.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_fin;
        end
    end

    // Capture the final value of the pass
    always_ff @(posedge i_clk) begin
        if (w_sqrt_done) begin
            r_res <= PROD_W'(w_root);
        end else if (w_div_done) begin
            r_res <= w_quo;
        end else if (w_mul_done) begin
            r_res <= w_prod;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== rtl/core/trapezoid_profile_point_timer_core.sv =====
// Trapezoid profile point timer: time at each trajectory point from a serial engine
// An engine pass is a multiply, optionally followed by a divide and a square root;
// a point at distance zero, at the end or on error needs no engine pass,
// a ramp point needs one and a cruise point two (two divide passes);
// a first point builds the profile in 4 or 5 passes.
// Throughput: one point at a time; the next request is taken once the previous finishes.
// Reset (synchronous, active low) clears registers, profile, distance and last time.
module trapezoid_profile_point_timer_core import tppt_pkg::*; #(
    parameter int DIST_BITS = DIST_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_req             o_out_req
);
    localparam logic [DIST_BITS-1:0] DIST_ONES = '1;
    localparam logic [TIME_BITS-1:0] TIME_ONES = '1;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_PREP = 13'b0000000000010,
        ST_VV   = 13'b0000000000100,
        ST_LA   = 13'b0000000001000,
        ST_PEAK = 13'b0000000010000,
        ST_TTA  = 13'b0000000100000,
        ST_RD   = 13'b0000001000000,
        ST_TA   = 13'b0000010000000,
        ST_FULL = 13'b0000100000000,
        ST_SQ   = 13'b0001000000000,
        ST_LIN  = 13'b0010000000000,
        ST_SUB  = 13'b0100000000000,
        ST_BUMP = 13'b1000000000000
    } t_state;

    function automatic logic [TIME_BITS-1:0] sat_q(input logic [PROD_W-1:0] q);
        if (q > PROD_W'(TIME_ONES)) begin
            return TIME_ONES;
        end
        return q[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_ONES : s[TIME_BITS-1:0];
    endfunction

    t_state                r_state;
    logic                  r_issued;
    logic [CFG_W-1:0]      r_total_length;
    logic [CFG_W-1:0]      r_cruise_speed;
    logic [CFG_W-1:0]      r_accel_rate;
    logic [DIST_BITS-1:0]  r_travelled;
    logic [TIME_BITS-1:0]  r_last_time;
    logic [CFG_W-1:0]      r_peak_speed;
    logic [CFG_W-1:0]      r_ramp_distance;
    logic [TIME_BITS-1:0]  r_ramp_time;
    logic [TIME_BITS-1:0]  r_coast_time;
    logic                  r_is_tri;
    logic                  r_out_valid;
    t_out_req              r_out_req;
    logic                  r_first;
    logic                  r_err;
    logic                  r_down;
    logic [WORD_W-1:0]     r_vv;
    logic [WORD_W-1:0]     r_s;
    logic [TIME_BITS-1:0]  r_t;
    logic [TIME_BITS-1:0]  r_lin;
    logic [TIME_BITS-1:0]  r_total;

    logic                  w_accept;
    logic [WORD_W-1:0]     w_len;
    logic [WORD_W-1:0]     w_acc;
    logic [WORD_W-1:0]     w_dist;
    logic [WORD_W-1:0]     w_seg_sum;
    logic [TIME_BITS-1:0]  w_total;
    logic                  w_at_zero;
    logic                  w_at_end;
    logic                  w_ramp_up;
    logic                  w_cruise;
    logic                  w_arith_st;
    logic                  w_start;
    logic                  w_adone;
    logic [PROD_W-1:0]     w_res;
    logic [TIME_BITS-1:0]  w_qsat;
    logic [TIME_BITS-1:0]  w_bump_t;
    logic                  w_err_out;
    logic                  w_bump_full;
    t_cmd                  w_cmd;

    assign w_accept   = i_in_valid & o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_len      = WORD_W'(r_total_length);
    assign w_acc      = WORD_W'(r_accel_rate);
    assign w_dist     = WORD_W'(r_travelled);
    assign w_seg_sum  = w_dist + WORD_W'(i_in_req.segment_length);
    assign w_total    = sat_add(sat_add(r_ramp_time, r_ramp_time), r_coast_time);
    assign w_qsat     = sat_q(w_res);

    // Pick the profile phase for the current distance
    assign w_at_zero  = (w_dist == '0);
    assign w_at_end   = (w_dist >= w_len);
    assign w_ramp_up  = (w_dist < WORD_W'(r_ramp_distance));
    assign w_cruise   = !r_is_tri && ((w_dist + WORD_W'(r_ramp_distance)) <= w_len);

    // Force a strict rise on follow-on points
    assign w_bump_t   = (!r_first && (r_t <= r_last_time))
                      ? sat_add(r_last_time, TIME_BITS'(BUMP_NS)) : r_t;

    assign w_arith_st = (r_state == ST_VV) || (r_state == ST_LA) || (r_state == ST_PEAK)
                     || (r_state == ST_TTA) || (r_state == ST_RD) || (r_state == ST_TA)
                     || (r_state == ST_FULL) || (r_state == ST_SQ) || (r_state == ST_LIN)
                     || (r_state == ST_SUB);
    assign w_start    = w_arith_st & ~r_issued;

    // Engine command for each step
    always_comb begin
        w_cmd = '0;
        case (r_state)
            ST_VV: begin
                w_cmd.mul_a = WORD_W'(r_cruise_speed);
                w_cmd.mul_b = WORD_W'(r_cruise_speed);
            end
            ST_LA: begin
                w_cmd.mul_a = w_len;
                w_cmd.mul_b = w_acc;
            end
            ST_PEAK: begin
                w_cmd.mul_a   = w_len;
                w_cmd.mul_b   = w_acc;
                w_cmd.do_sqrt = 1'b1;
            end
            ST_TTA: begin
                w_cmd.mul_a    = w_len;
                w_cmd.mul_b    = NS2;
                w_cmd.divisor  = w_acc;
                w_cmd.do_div   = 1'b1;
                w_cmd.do_sqrt  = 1'b1;
                w_cmd.round_up = 1'b1;
            end
            ST_RD: begin
                w_cmd.mul_a   = WORD_W'(r_cruise_speed);
                w_cmd.mul_b   = WORD_W'(r_cruise_speed);
                w_cmd.addend  = (w_acc << 1) - 1'b1;
                w_cmd.divisor = w_acc << 1;
                w_cmd.do_div  = 1'b1;
            end
            ST_TA: begin
                w_cmd.mul_a   = WORD_W'(r_cruise_speed);
                w_cmd.mul_b   = NS1;
                w_cmd.addend  = w_acc >> 1;
                w_cmd.divisor = w_acc;
                w_cmd.do_div  = 1'b1;
            end
            ST_FULL: begin
                w_cmd.mul_a   = w_len;
                w_cmd.mul_b   = NS1;
                w_cmd.addend  = WORD_W'(r_cruise_speed) >> 1;
                w_cmd.divisor = WORD_W'(r_cruise_speed);
                w_cmd.do_div  = 1'b1;
            end
            ST_SQ: begin
                w_cmd.mul_a    = r_s;
                w_cmd.mul_b    = NS2;
                w_cmd.divisor  = w_acc;
                w_cmd.do_div   = 1'b1;
                w_cmd.do_sqrt  = 1'b1;
                w_cmd.round_up = 1'b1;
            end
            ST_LIN: begin
                w_cmd.mul_a   = w_dist;
                w_cmd.mul_b   = NS1;
                w_cmd.addend  = WORD_W'(r_peak_speed) >> 1;
                w_cmd.divisor = WORD_W'(r_peak_speed);
                w_cmd.do_div  = 1'b1;
            end
            ST_SUB: begin
                w_cmd.mul_a   = WORD_W'(r_peak_speed);
                w_cmd.mul_b   = NS1;
                w_cmd.addend  = w_acc;
                w_cmd.divisor = w_acc << 1;
                w_cmd.do_div  = 1'b1;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    tppt_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (w_cmd),
        .o_done  (w_adone),
        .o_res   (w_res)
    );

    // Sequencer, registers and trajectory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_issued        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_total_length  <= '0;
            r_cruise_speed  <= '0;
            r_accel_rate    <= '0;
            r_travelled     <= '0;
            r_last_time     <= '0;
            r_peak_speed    <= '0;
            r_ramp_distance <= '0;
            r_ramp_time     <= '0;
            r_coast_time    <= '0;
            r_is_tri        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_TOTAL_LENGTH: r_total_length <= i_cfg_data;
                    REG_CRUISE_SPEED: r_cruise_speed <= i_cfg_data;
                    REG_ACCEL_RATE:   r_accel_rate   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_start) begin
                r_issued <= 1'b1;
            end else if (w_adone) begin
                r_issued <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_in_req.first) begin
                            r_travelled <= '0;
                            r_last_time <= '0;
                        end else if (w_seg_sum > WORD_W'(DIST_ONES)) begin
                            r_travelled <= DIST_ONES;
                        end else begin
                            r_travelled <= w_seg_sum[DIST_BITS-1:0];
                        end
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (r_err) begin
                        if (r_first) begin
                            r_peak_speed    <= '0;
                            r_ramp_distance <= '0;
                            r_ramp_time     <= '0;
                            r_coast_time    <= '0;
                            r_is_tri        <= 1'b0;
                        end
                        r_state <= ST_BUMP;
                    end else if (r_first) begin
                        r_state <= ST_VV;
                    end else if (w_at_zero || w_at_end) begin
                        r_state <= ST_BUMP;
                    end else if (w_ramp_up) begin
                        r_state <= ST_SQ;
                    end else if (w_cruise) begin
                        r_state <= (r_peak_speed == '0) ? ST_BUMP : ST_LIN;
                    end else begin
                        r_state <= ST_SQ;
                    end
                end
                ST_VV: begin
                    if (w_adone) begin
                        r_state <= ST_LA;
                    end
                end
                ST_LA: begin
                    if (w_adone) begin
                        r_is_tri <= r_vv > w_res[WORD_W-1:0];
                        r_state  <= (r_vv > w_res[WORD_W-1:0]) ? ST_PEAK : ST_RD;
                    end
                end
                ST_PEAK: begin
                    if (w_adone) begin
                        r_peak_speed    <= w_res[CFG_W-1:0];
                        r_ramp_distance <= CFG_W'(({1'b0, r_total_length} + 1'b1) >> 1);
                        r_coast_time    <= '0;
                        r_state         <= ST_TTA;
                    end
                end
                ST_TTA: begin
                    if (w_adone) begin
                        r_ramp_time <= w_qsat;
                        r_state     <= ST_BUMP;
                    end
                end
                ST_RD: begin
                    if (w_adone) begin
                        r_ramp_distance <= w_res[CFG_W-1:0];
                        r_peak_speed    <= r_cruise_speed;
                        r_state         <= ST_TA;
                    end
                end
                ST_TA: begin
                    if (w_adone) begin
                        r_ramp_time <= w_qsat;
                        if (r_cruise_speed == '0) begin
                            r_coast_time <= TIME_ONES;
                            r_state      <= ST_BUMP;
                        end else begin
                            r_state <= ST_FULL;
                        end
                    end
                end
                ST_FULL: begin
                    if (w_adone) begin
                        r_coast_time <= (w_qsat > r_ramp_time) ? (w_qsat - r_ramp_time) : '0;
                        r_state      <= ST_BUMP;
                    end
                end
                ST_SQ: begin
                    if (w_adone) begin
                        r_state <= ST_BUMP;
                    end
                end
                ST_LIN: begin
                    if (w_adone) begin
                        r_state <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    if (w_adone) begin
                        r_state <= ST_BUMP;
                    end
                end
                ST_BUMP: begin
                    // Hold until the output register is free
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        if (!r_err) begin
                            r_last_time <= w_bump_t;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Working values and the output request
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_first <= i_in_req.first;
                    r_err   <= (r_total_length == '0) || (r_accel_rate == '0);
                end
            end
            ST_PREP: begin
                r_total <= w_total;
                r_t     <= '0;
                r_down  <= !w_ramp_up;
                r_s     <= w_ramp_up ? (w_dist << 1) : ((w_len - w_dist) << 1);
                if (!r_first && !w_at_zero) begin
                    if (w_at_end) begin
                        r_t <= w_total;
                    end else if (!w_ramp_up && w_cruise && (r_peak_speed == '0)) begin
                        r_t <= TIME_ONES;
                    end
                end
            end
            ST_VV: begin
                if (w_adone) begin
                    r_vv <= w_res[WORD_W-1:0];
                end
            end
            ST_SQ: begin
                if (w_adone) begin
                    if (r_down) begin
                        r_t <= (r_total > w_qsat) ? (r_total - w_qsat) : '0;
                    end else begin
                        r_t <= w_qsat;
                    end
                end
            end
            ST_LIN: begin
                if (w_adone) begin
                    r_lin <= sat_add(r_ramp_time, w_qsat);
                end
            end
            ST_SUB: begin
                if (w_adone) begin
                    r_t <= (r_lin > w_qsat) ? (r_lin - w_qsat) : '0;
                end
            end
            ST_BUMP: begin
                if (!r_out_valid) begin
                    r_out_req.time_ns <= r_err ? '0 : OUT_TIME_W'(w_bump_t);
                    r_out_req.error   <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign w_err_out   = o_out_valid && o_out_req.error;
    assign w_bump_full = (r_state == ST_BUMP) && r_out_valid && !i_out_ready;

    `include "trapezoid_profile_point_timer_core_assert.svh"

    // An error result always carries a zero time
    `TPPT_ASSERT_IMPLY(a_err_zero_time, i_clk, i_rst_n, w_err_out, o_out_req.time_ns == '0)
    // An accepted request makes the block busy
    `TPPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_in_ready)
    // A finished point waits while the output register is full
    `TPPT_ASSERT_NEXT(a_hold_when_full, i_clk, i_rst_n, w_bump_full, r_state == ST_BUMP)
endmodule

// ===== verif/trapezoid_profile_point_timer_checker.sv =====
// Point timer checker: predicts each point time and compares it with the block's output
module trapezoid_profile_point_timer_checker import tppt_pkg::*; #(
    parameter int DIST_BITS = DIST_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_req              i_in_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_req             i_out_req,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] TIME_CAP = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [63:0] DIST_CAP = (64'd1 << DIST_BITS) - 64'd1;

    // Live registers and the profile derived at the last first point
    logic [63:0] reg_len, reg_speed, reg_accel;
    logic [63:0] dist_done, prev_time, peak_rate, ramp_len, ramp_ns, coast_ns;
    logic        tri_shape;
    t_out_req    expected_points[$];
    int          fail_count;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [63:0] clamp_time(logic [63:0] x);
        return (x > TIME_CAP) ? TIME_CAP : x;
    endfunction

    function automatic logic [63:0] add_time(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s < a) return TIME_CAP;
        return clamp_time(s);
    endfunction

    // round(x*y/d), saturating
    function automatic logic [63:0] scaled_round(logic [63:0] x, logic [63:0] y,
                                                 logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, x} * {64'd0, y} + {64'd0, d >> 1}) / {64'd0, d};
        if (q[127:64] != 64'd0) return TIME_CAP;
        return clamp_time(q[63:0]);
    endfunction

    // Integer square root rounded half up
    function automatic logic [63:0] root_round(logic [127:0] n);
        logic [63:0] r, t;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= n) r = t;
        end
        if (!(n <= {64'd0, r} * {64'd0, r} + {64'd0, r}) && r != '1) r = r + 64'd1;
        return r;
    endfunction

    // Time in ns to cover half of distance s from rest
    function automatic logic [63:0] ramp_root(logic [63:0] s, logic [63:0] a);
        return clamp_time(root_round(({64'd0, s} * {64'd0, NS2}) / {64'd0, a}));
    endfunction

    function automatic void clear_shape();
        peak_rate = 0; ramp_len = 0; ramp_ns = 0; coast_ns = 0; tri_shape = 1'b0;
    endfunction

    function automatic void build_shape();
        logic [63:0] vv, la, full;
        vv = reg_speed * reg_speed;
        la = reg_len * reg_accel;
        tri_shape = vv > la;
        if (tri_shape) begin
            peak_rate = root_round({64'd0, la});
            if (peak_rate * peak_rate > la) peak_rate = peak_rate - 64'd1;
            ramp_len = (reg_len + 64'd1) >> 1;
            ramp_ns  = ramp_root(reg_len, reg_accel);
            coast_ns = 0;
        end else begin
            peak_rate = reg_speed;
            ramp_len  = (vv + 64'd2 * reg_accel - 64'd1) / (64'd2 * reg_accel);
            ramp_ns   = scaled_round(reg_speed, NS1, reg_accel);
            if (reg_speed == 0) begin
                coast_ns = TIME_CAP;
            end else begin
                full     = scaled_round(reg_len, NS1, reg_speed);
                coast_ns = (full > ramp_ns) ? full - ramp_ns : 64'd0;
            end
        end
    endfunction

    // Profile time at distance d
    function automatic logic [63:0] profile_time(logic [63:0] d);
        logic [63:0] total, lin, sub, s;
        total = add_time(add_time(ramp_ns, ramp_ns), coast_ns);
        if (d == 0) return 64'd0;
        if (d >= reg_len) return total;
        if (d < ramp_len) return ramp_root(64'd2 * d, reg_accel);
        if (!tri_shape && d + ramp_len <= reg_len) begin
            if (peak_rate == 0) return TIME_CAP;
            lin = add_time(ramp_ns, scaled_round(d, NS1, peak_rate));
            sub = scaled_round(peak_rate, NS1, 64'd2 * reg_accel);
            return (lin > sub) ? lin - sub : 64'd0;
        end
        s = ramp_root(64'd2 * (reg_len - d), reg_accel);
        return (total > s) ? total - s : 64'd0;
    endfunction

    function automatic t_out_req predict_point(t_in_req req);
        t_out_req    res;
        logic        err;
        logic [63:0] t;
        err = (reg_len == 0) || (reg_accel == 0);
        if (req.first) begin
            dist_done = 0;
            prev_time = 0;
            if (err) clear_shape();
            else build_shape();
        end else begin
            dist_done = dist_done + {32'd0, req.segment_length};
            if (dist_done > DIST_CAP) dist_done = DIST_CAP;
        end
        if (err) begin
            res.time_ns = '0;
            res.error   = 1'b1;
            return res;
        end
        t = profile_time(dist_done);
        if (!req.first && t <= prev_time) t = add_time(prev_time, BUMP_NS);
        prev_time   = t;
        res.time_ns = t[OUT_TIME_W-1:0];
        res.error   = 1'b0;
        return res;
    endfunction

    // Track registers, predict on each accepted request, compare each accepted result
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            reg_len = 0; reg_speed = 0; reg_accel = 0;
            dist_done = 0; prev_time = 0;
            clear_shape();
            expected_points.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_TOTAL_LENGTH: reg_len   = {32'd0, i_cfg_data};
                    REG_CRUISE_SPEED: reg_speed = {32'd0, i_cfg_data};
                    REG_ACCEL_RATE:   reg_accel = {32'd0, i_cfg_data};
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_points.insert(expected_points.size(), predict_point(i_in_req));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result time_ns=%0d error=%0b", $realtime,
                             i_out_req.time_ns, i_out_req.error);
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (want.time_ns !== i_out_req.time_ns) begin
                        $display("%0t: time_ns expected %0d actual %0d", $realtime,
                                 want.time_ns, i_out_req.time_ns);
                        fail_count++;
                    end
                    if (want.error !== i_out_req.error) begin
                        $display("%0t: error expected %0b actual %0b", $realtime,
                                 want.error, i_out_req.error);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_points.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Point timer testbench top: clock, reset, stimulus, output stalls and verdict
module testbench;
    import tppt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 900;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TOTAL_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_req              in_req = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_req             out_req;
    int                   fail_count, pending;
    int                   cycles = 0;
    int                   burst_left = 0;
    int                   sent = 0;

    trapezoid_profile_point_timer_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_req(in_req),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_req(out_req)
    );

    trapezoid_profile_point_timer_checker point_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_req(in_req),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_req(out_req),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result side: the stall rate is redrawn periodically
    int stall_left = 0;
    int stall_pct = 0;
    always @(posedge clk) begin
        if (cycles % 500 == 0) stall_pct = (($urandom_range(0, 2)) == 0) ? 0 :
                                           (($urandom_range(0, 1)) == 0) ? 10 : 50;
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
        end
    end

    // Write the three profile registers back to back
    task automatic set_profile(logic [31:0] len, logic [31:0] speed, logic [31:0] accel);
        cfg_wr_en <= 1'b1; cfg_index <= REG_TOTAL_LENGTH; cfg_data <= len;
        @(posedge clk);
        cfg_index <= REG_CRUISE_SPEED; cfg_data <= speed;
        @(posedge clk);
        cfg_index <= REG_ACCEL_RATE; cfg_data <= accel;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send one point request; gaps fall between random bursts
    task automatic send_point(logic [31:0] seg, logic first);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
        burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req.segment_length <= seg;
        in_req.first <= first;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Hold off until every pending point has come back; the first edge lets the
    // checker count the request taken at the previous one
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Pick a profile: mostly realistic, some triangular and some extremes
    task automatic random_profile(output logic [31:0] len);
        logic [31:0] speed, accel;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                len = $urandom_range(1, 2000000); speed = $urandom_range(1000, 500000);
                accel = $urandom_range(1000, 5000000);
            end
            4, 5: begin
                len = $urandom_range(1, 100000); speed = $urandom_range(100000, 2000000);
                accel = $urandom_range(1, 100000);
            end
            6: begin
                len = $urandom(); speed = $urandom(); accel = $urandom();
            end
            7: begin
                len = $urandom_range(1, 1000000); speed = 0; accel = $urandom_range(1, 1000000);
            end
            8: begin
                len = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 1000000);
                speed = $urandom_range(0, 100000);
                accel = (len == 0) ? $urandom() : 32'd0;
            end
            default: begin
                len = '1; speed = ($urandom_range(0, 1) == 0) ? '1 : 32'd1; accel = '1;
            end
        endcase
        set_profile(len, speed, accel);
    endtask

    initial begin
        logic [31:0] len, base, seg;
        int          npts;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: points before any first point use the reset profile
        set_profile(32'd1000000, 32'd100000, 32'd1000000);
        send_point(32'd1000, 1'b0);
        send_point(32'd1000, 1'b0);
        // Walk a trapezoid: start, zero step, ramp, cruise, past end, saturate
        send_point('1, 1'b1);
        send_point(32'd0, 1'b0);
        send_point(32'd1, 1'b0);
        send_point(32'd4000, 1'b0);
        send_point(32'd400000, 1'b0);
        send_point(32'd500000, 1'b0);
        send_point(32'd200000, 1'b0);
        send_point('1, 1'b0);
        drain();
        // Triangular profile, then change length mid-trajectory
        set_profile(32'd1000000, 32'd10000000, 32'd1000000);
        send_point(32'd0, 1'b1);
        send_point(32'd300000, 1'b0);
        drain();
        set_profile(32'd3000000, 32'd10000000, 32'd1000000);
        send_point(32'd400000, 1'b0);
        drain();
        // Error cases: zero length, zero acceleration
        set_profile(32'd0, 32'd1000, 32'd1000);
        send_point(32'd0, 1'b1);
        send_point(32'd5, 1'b0);
        drain();
        set_profile(32'd1000, 32'd1000, 32'd0);
        send_point(32'd5, 1'b0);
        send_point(32'd0, 1'b1);
        drain();
        // Zero speed: cruise saturates and the forced rise stays at the maximum
        set_profile(32'd1000000, 32'd0, 32'd1000);
        send_point(32'd0, 1'b1);
        send_point(32'd500000, 1'b0);
        send_point(32'd10, 1'b0);
        drain();
        // All-ones registers
        set_profile('1, '1, '1);
        send_point(32'd0, 1'b1);
        send_point(32'd1, 1'b0);
        send_point('1, 1'b0);
        drain();

        // Random trajectories with some noise and mid-trajectory register changes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_profile(len);
            npts = $urandom_range(3, 30);
            base = (len / npts) + 1;
            send_point($urandom(), 1'b1);
            for (int i = 0; i < npts; i++) begin
                case ($urandom_range(0, 19))
                    0: seg = $urandom();
                    1: seg = 32'd0;
                    2: seg = $urandom_range(0, 3);
                    default: seg = base + $urandom_range(0, base / 2);
                endcase
                send_point(seg, $urandom_range(0, 49) == 0);
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                    cfg_wr_en <= 1'b1;
                    cfg_index <= ($urandom_range(0, 1) == 0) ? REG_TOTAL_LENGTH : REG_ACCEL_RATE;
                    cfg_data <= $urandom_range(0, 3000000);
                    @(posedge clk);
                    cfg_wr_en <= 1'b0;
                end
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
